>>> rtl/core/assert_macros.svh
// assertion macros for the rtl of the base58 decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define B58_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define B58_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/b58_pkg.sv
// types, constants and the alphabet lookup of the base58 decoder
`timescale 1ns / 1ps

package b58_pkg;

  localparam int unsigned ACC_BYTES_DEF = 32;
  localparam int unsigned RADIX         = 58;
  localparam int unsigned DIGIT_W       = 6;
  localparam int unsigned MAC_W         = 14;

  // alphabet lookup result
  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
  } b58_digit_t;

  // sequencer to accumulator
  typedef struct packed {
    logic               load;
    logic [DIGIT_W-1:0] digit;
    logic               fold;
    logic               drain;
  } b58_acc_ctrl_t;

  // accumulator to sequencer
  typedef struct packed {
    logic [7:0] head_byte;
    logic       carry_nz;
  } b58_acc_stat_t;

  // map one ascii code to its base58 digit
  function automatic b58_digit_t b58_digit(input logic [7:0] code);
    b58_digit_t r;
    r.valid = 1'b1;
    r.digit = '0;
    if (code >= 8'h31 && code <= 8'h39) begin
      r.digit = DIGIT_W'(code - 8'h31);
    end else if (code >= 8'h41 && code <= 8'h48) begin
      r.digit = DIGIT_W'(code - 8'h41 + 8'd9);
    end else if (code >= 8'h4a && code <= 8'h4e) begin
      r.digit = DIGIT_W'(code - 8'h4a + 8'd17);
    end else if (code >= 8'h50 && code <= 8'h5a) begin
      r.digit = DIGIT_W'(code - 8'h50 + 8'd22);
    end else if (code >= 8'h61 && code <= 8'h6b) begin
      r.digit = DIGIT_W'(code - 8'h61 + 8'd33);
    end else if (code >= 8'h6d && code <= 8'h7a) begin
      r.digit = DIGIT_W'(code - 8'h6d + 8'd44);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/b58_acc.sv
// big-endian accumulator as a rotating byte line with one shared multiply-add
`timescale 1ns / 1ps

module b58_acc import b58_pkg::*; #(
  parameter int unsigned ACC_BYTES = ACC_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b58_acc_ctrl_t ctrl_i,
  output b58_acc_stat_t stat_o
);

  logic [7:0]         acc_q [ACC_BYTES];
  logic [DIGIT_W-1:0] carry_q;
  logic [MAC_W-1:0]   mac;

  // tail byte times radix plus running carry
  assign mac = MAC_W'(acc_q[ACC_BYTES-1]) * MAC_W'(RADIX) + MAC_W'(carry_q);

  assign stat_o.head_byte = acc_q[0];
  assign stat_o.carry_nz  = (mac[MAC_W-1:8] != '0);

  // fold rotates toward the tail, drain shifts toward the head and fills zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ACC_BYTES; i++) acc_q[i] <= '0;
      carry_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        carry_q <= ctrl_i.digit;
      end else if (ctrl_i.fold) begin
        carry_q <= mac[MAC_W-1:8];
      end
      if (ctrl_i.fold) begin
        acc_q[0] <= mac[7:0];
        for (int i = 1; i < ACC_BYTES; i++) acc_q[i] <= acc_q[i-1];
      end else if (ctrl_i.drain) begin
        for (int i = 0; i < ACC_BYTES - 1; i++) acc_q[i] <= acc_q[i+1];
        acc_q[ACC_BYTES-1] <= '0;
      end
    end
  end

endmodule

>>> rtl/core/base58_string_decoder_core.sv
// top level of the base58 string decoder: sequencer and output word register
`timescale 1ns / 1ps

// Usage:
// The slave channel takes one ascii character per word (tdata), tlast marks
// the final character of a string. The master channel gives the decoded value
// as bytes, most significant first, tlast on the final byte; tuser[0] marks a
// zero value (one word, data zero), tuser[1] flags that the value wrapped
// beyond ACC_BYTES bytes somewhere in the string.
// Sequence: a base58 digit is taken while idle, then one byte
// multiply-add walks the whole accumulator line; an invalid or ignored
// character leaves the sequencer idle. A last character then starts the
// draining, one byte per cycle while the receiver does not stall.
// Leading zero bytes are skipped, so a string gives 1 to ACC_BYTES words.
// s_axis_tready_o is high only while the sequencer is idle.
// Reset clears the accumulator, the flags and the output word register.
// When the receiver stalls, the word is held and draining pauses.
module base58_string_decoder_core import b58_pkg::*; #(
  parameter int unsigned ACC_BYTES = ACC_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,
  output logic [1:0] m_axis_tuser_o    // [0] empty_value, [1] overflowed
);

`include "assert_macros.svh"

  localparam int unsigned CNT_W = (ACC_BYTES > 1) ? $clog2(ACC_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ACC_BYTES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_EMIT
  } state_e;

  state_e        state_q;
  logic [CNT_W-1:0] cnt_q;
  logic          stopped_q, ovf_q, last_q, started_q;
  logic          m_valid_q, m_last_q;
  logic [7:0]    m_data_q;
  logic [1:0]    m_user_q;

  b58_digit_t    dig;
  b58_acc_ctrl_t acc_ctrl;
  b58_acc_stat_t acc_stat;
  logic          in_acc, do_fold, step_ok, head_nz, cnt_end, out_load;

  b58_acc #(.ACC_BYTES(ACC_BYTES)) u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .stat_o (acc_stat)
  );

  // input decode and step conditions
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign dig      = b58_digit(s_axis_tdata_i);
  assign do_fold  = in_acc && !stopped_q && dig.valid;
  assign step_ok  = !m_valid_q || m_axis_tready_i;
  assign head_nz  = (acc_stat.head_byte != '0);
  assign cnt_end  = (cnt_q == CNT_MAX);
  assign out_load = (state_q == ST_EMIT) && step_ok && (head_nz || started_q || cnt_end);

  // accumulator control
  always_comb begin
    acc_ctrl.load  = do_fold;
    acc_ctrl.digit = dig.digit;
    acc_ctrl.fold  = (state_q == ST_FOLD);
    acc_ctrl.drain = (state_q == ST_EMIT) && step_ok;
  end

  // sequencer and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      stopped_q <= 1'b0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      started_q <= 1'b0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= acc_stat.head_byte;
        m_last_q  <= cnt_end;
        m_user_q  <= {ovf_q, !(head_nz || started_q)};
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q <= s_axis_tlast_i;
            if (!stopped_q && !dig.valid) stopped_q <= 1'b1;
            if (do_fold) begin
              state_q <= ST_FOLD;
            end else if (s_axis_tlast_i) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_FOLD: begin
          if (cnt_end) begin
            cnt_q <= '0;
            if (acc_stat.carry_nz) ovf_q <= 1'b1;
            state_q <= last_q ? ST_EMIT : ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (step_ok) begin
            if (cnt_end) begin
              cnt_q     <= '0;
              started_q <= 1'b0;
              stopped_q <= 1'b0;
              ovf_q     <= 1'b0;
              state_q   <= ST_IDLE;
            end else begin
              cnt_q     <= cnt_q + 1'b1;
              started_q <= started_q || head_nz;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

  `B58_ASSERT_NOW(a_idle_cnt_zero, s_axis_tready_o, cnt_q == '0, "counter not clear when idle")
  `B58_ASSERT_NOW(a_empty_is_last, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tlast_o && m_axis_tdata_o == '0, "empty word not a single zero last word")
  `B58_ASSERT_NOW(a_no_load_in_fold, state_q == ST_FOLD, !out_load, "output loaded while folding")
  `B58_ASSERT_NEXT(a_emit_end_clears, state_q == ST_EMIT && step_ok && cnt_end, !stopped_q && !ovf_q && !started_q, "flags not cleared at end of string")

endmodule

>>> tb/tb_base58_string_decoder_core.sv
// testbench for the base58 string decoder: random strings, byte-level prediction and checks
`timescale 1ns / 1ps

module tb_base58_string_decoder_core;
  import b58_pkg::*;

  localparam int unsigned NB        = ACC_BYTES_DEF;
  localparam int unsigned ACC_W     = 8 * NB;
  localparam int          CHAR_GOAL = 460;
  localparam int          HOLD_LEN  = 700;
  localparam string       ALPHABET  =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // one character word on the slave side
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  // one decoded byte word on the master side
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       wrapped;
  } byte_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;

  char_word_t char_q[$];
  byte_word_t decoded_q[$];

  // decoder shadow state
  logic [ACC_W-1:0] value_acc = '0;
  logic             value_halted = 1'b0;
  logic             value_wrapped = 1'b0;

  logic char_taken = 1'b0;
  int   chars_total = 0;
  int   chars_accepted = 0;
  int   strings_done = 0;
  int   strings_wrapped = 0;
  int   strings_halted = 0;
  int   strings_empty = 0;
  int   bytes_checked = 0;
  int   errors = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  base58_string_decoder_core #(.ACC_BYTES(NB)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // alphabet position of a code, -1 when it is no base58 digit
  function automatic int alphabet_pos(input logic [7:0] code);
    for (int i = 0; i < 58; i++) begin
      if (ALPHABET[i] == code) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] random_digit_char();
    return ALPHABET[$urandom_range(0, 57)];
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (alphabet_pos(c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // idle percentage per phase: receiver slower first, sender slower second, none last
  function automatic int idle_pct(input bit receiver);
    if (chars_accepted < chars_total / 3) return receiver ? 48 : 33;
    if (chars_accepted < 2 * chars_total / 3) return receiver ? 33 : 48;
    return 0;
  endfunction

  // fold one accepted character into the shadow value, queue bytes on the last one
  task automatic decode_char(input char_word_t w);
    logic [ACC_W+7:0] wide;
    int               pos;
    int               first;
    byte_word_t       b;
    pos = alphabet_pos(w.code);
    if (!value_halted) begin
      if (pos >= 0) begin
        wide = ({8'h00, value_acc} * 58) + pos;
        if (wide[ACC_W +: 8] != 8'h00) value_wrapped = 1'b1;
        value_acc = wide[ACC_W-1:0];
      end else begin
        value_halted = 1'b1;
      end
    end
    if (w.last) begin
      first = NB;
      for (int i = NB - 1; i >= 0; i--) begin
        if (value_acc[8*(NB-1-i) +: 8] != 8'h00) first = i;
      end
      strings_done++;
      if (value_wrapped) strings_wrapped++;
      if (value_halted) strings_halted++;
      if (first == NB) begin
        strings_empty++;
        b = '{data: 8'h00, last: 1'b1, empty: 1'b1, wrapped: value_wrapped};
        decoded_q.push_back(b);
      end else begin
        for (int i = first; i < NB; i++) begin
          b.data    = value_acc[8*(NB-1-i) +: 8];
          b.last    = (i == NB - 1);
          b.empty   = 1'b0;
          b.wrapped = value_wrapped;
          decoded_q.push_back(b);
        end
      end
      value_acc     = '0;
      value_halted  = 1'b0;
      value_wrapped = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      char_q.push_back('{code: s[i], last: (i == s.len() - 1)});
    end
  endtask

  task automatic queue_char(input logic [7:0] c, input logic last);
    char_q.push_back('{code: c, last: last});
  endtask

  // one random string: well-formed, broken by a bad character, or pure noise
  task automatic queue_random_string(input int len);
    int kind;
    int bad_at;
    int ones;
    logic [7:0] c;
    kind   = $urandom_range(0, 99);
    bad_at = $urandom_range(0, len - 1);
    ones   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < len; i++) begin
      if (kind < 10) c = 8'($urandom_range(0, 255));
      else if (kind < 25 && i == bad_at) c = random_bad_char();
      else if (i < ones) c = "1";
      else c = random_digit_char();
      queue_char(c, i == len - 1);
    end
  endtask

  // slave side driver
  always @(negedge clk_i) begin : drive_chars
    logic       nv;
    logic [7:0] nd;
    logic       nl;
    char_word_t w;
    nv = s_axis_tvalid_i;
    nd = s_axis_tdata_i;
    nl = s_axis_tlast_i;
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (!(s_axis_tvalid_i && !char_taken)) begin
      nv = 1'b0;
      if (char_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        w  = char_q.pop_front();
        nv = 1'b1;
        nd = w.code;
        nl = w.last;
      end
    end
    s_axis_tvalid_i <= nv;
    s_axis_tdata_i  <= nd;
    s_axis_tlast_i  <= nl;
  end

  // master side receiver, with one long hold-off at the start of the last phase
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (!hold_done && chars_accepted >= 2 * chars_total / 3) begin
      hold_done       <= 1'b1;
      hold_left       <= HOLD_LEN;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // monitor: predict on accepted characters, check accepted bytes
  always @(posedge clk_i) begin : watch_ports
    byte_word_t want;
    if (!rst_ni) begin
      char_taken <= 1'b0;
    end else begin
      char_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        bytes_checked++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected byte word", m_axis_tdata_o, 0);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata_o !== want.data)
            report_mismatch("data_byte", m_axis_tdata_o, want.data);
          if (m_axis_tlast_o !== want.last)
            report_mismatch("last_byte", m_axis_tlast_o, want.last);
          if (m_axis_tuser_o[0] !== want.empty)
            report_mismatch("empty_value", m_axis_tuser_o[0], want.empty);
          if (m_axis_tuser_o[1] !== want.wrapped)
            report_mismatch("overflowed", m_axis_tuser_o[1], want.wrapped);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        chars_accepted++;
        decode_char('{code: s_axis_tdata_i, last: s_axis_tlast_i});
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int len;
    // directed: zero value, single digits, leading ones, bad characters, boundaries
    queue_text("1");
    queue_text("z");
    queue_text("21");
    queue_text("112");
    queue_text("0");
    queue_char("2", 1'b0);
    queue_char(8'hff, 1'b0);
    queue_char("z", 1'b1);
    queue_char(8'h80, 1'b0);
    queue_char("z", 1'b1);
    queue_text("3l");
    queue_text("aO");
    queue_char(8'h00, 1'b1);
    queue_text("9AHJNPZakmz");
    // long string right away so the accumulator wraps and fills all bytes
    queue_char(random_bad_char() == 8'h00 ? "z" : ALPHABET[$urandom_range(1, 57)], 1'b0);
    for (int i = 1; i < 46; i++) queue_char(random_digit_char(), i == 45);
    while (char_q.size() < CHAR_GOAL) begin
      len = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 50) : $urandom_range(1, 10);
      queue_random_string(len);
    end
    chars_total = char_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_q.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (decoded_q.size() > 0) @(posedge clk_i);
    repeat (NB + 50) @(posedge clk_i);

    if (decoded_q.size() > 0) begin
      $display("%0d expected byte words never arrived", decoded_q.size());
      errors++;
    end
    $display("covered %0d characters in %0d strings, %0d bytes checked",
             chars_accepted, strings_done, bytes_checked);
    $display("strings wrapped %0d, cut by a bad character %0d, zero valued %0d",
             strings_wrapped, strings_halted, strings_empty);
    if (errors == 0) begin
      $display("base58_string_decoder_core verification clean");
    end else begin
      $display("base58_string_decoder_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("base58_string_decoder_core verification failed");
    $finish;
  end

endmodule
